@@ src/ipd_pkg.sv @@
`default_nettype none

package ipd_pkg;

  localparam int unsigned GapW   = 16;
  localparam int unsigned CountW = 6;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned KeyW   = 4;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned NumKeys = 12;

  localparam logic [KeyW-1:0] KeyNone = KeyW'(12);

  localparam logic [GapW-1:0]   OneLimitRst   = GapW'(1300);
  localparam logic [GapW-1:0]   StartLimitRst = GapW'(2500);
  localparam logic [GapW-1:0]   IdleLimitRst  = GapW'(35000);
  localparam logic [CountW-1:0] FrameEdgesRst = CountW'(34);

  // digits 0-9, then mute, then last
  localparam logic [CodeW-1:0] KeyCodes [NumKeys] = '{
    32'h02FD00FF, 32'h02FD807F, 32'h02FD40BF, 32'h02FDC03F,
    32'h02FD20DF, 32'h02FDA05F, 32'h02FD609F, 32'h02FDE01F,
    32'h02FD10EF, 32'h02FD906F, 32'h02FD08F7, 32'h02FD02FD
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgOneLimit   = 8'd0,
    CfgStartLimit = 8'd1,
    CfgIdleLimit  = 8'd2,
    CfgFrameEdges = 8'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ src/ipd_key_match.sv @@
`default_nettype none

module ipd_key_match import ipd_pkg::*; (
  input  wire logic [CodeW-1:0] code_i,
  output logic      [KeyW-1:0]  key_index_o
);

  // lowest matching index wins
  always_comb begin
    key_index_o = KeyNone;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (code_i == KeyCodes[i]) begin
        key_index_o = KeyW'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/ir_pulse_distance_decoder.sv @@
// An accepted gap word's result word is captured in the output register at the accepting edge.
// Throughput: one gap word per cycle while results are taken; the output register frees in the cycle it is taken.
// Each edge is classified and the frame state updated in a single pass of compare logic.
// Reset: limits return to 1300/2500/35000 us and the frame length to 34 gap words, decoder armed for a first edge,
// edge count and shift register cleared, output register empty.
`default_nettype none

module ir_pulse_distance_decoder import ipd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [GapW-1:0]     gap_us_i,

  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     frame_done_o,
  output logic      [CodeW-1:0]    code_o,
  output logic      [KeyW-1:0]     key_index_o
);

  logic [GapW-1:0]   one_limit_q, start_limit_q, idle_limit_q;
  logic [CountW-1:0] frame_edges_q;

  logic              armed_q, armed_d;
  logic [CountW-1:0] edge_count_q, edge_count_d;
  logic [CodeW-1:0]  shift_q, shift_d;

  logic              out_valid_q;
  logic              frame_done_q;
  logic [CodeW-1:0]  code_q;
  logic [KeyW-1:0]   key_index_q;

  logic              in_accept;
  logic              done;
  logic [CountW-1:0] count_inc;
  logic [KeyW-1:0]   key_match;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_limit_q   <= OneLimitRst;
      start_limit_q <= StartLimitRst;
      idle_limit_q  <= IdleLimitRst;
      frame_edges_q <= FrameEdgesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOneLimit:   one_limit_q   <= cfg_data_i;
        CfgStartLimit: start_limit_q <= cfg_data_i;
        CfgIdleLimit:  idle_limit_q  <= cfg_data_i;
        CfgFrameEdges: frame_edges_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // edge classification and frame state update
  always_comb begin
    logic [CountW-1:0] cnt;
    logic [CodeW-1:0]  sr;
    cnt     = edge_count_q;
    sr      = shift_q;
    armed_d = armed_q;
    if (armed_q) begin
      armed_d = 1'b0;
    end else begin
      if (gap_us_i >= idle_limit_q) begin
        cnt = '0;
      end else if (gap_us_i >= start_limit_q) begin
        sr  = '0;
        cnt = CountW'(1);
      end
      // with the one limit below the start limit, a gap exactly on a limit shifts nothing
      if (gap_us_i > one_limit_q && gap_us_i < start_limit_q) begin
        sr = {sr[CodeW-2:0], 1'b1};
      end else if (gap_us_i < one_limit_q) begin
        sr = {sr[CodeW-2:0], 1'b0};
      end else if (gap_us_i > start_limit_q) begin
        sr = '0;
      end
    end
    count_inc    = cnt + CountW'(1);
    done         = (count_inc == frame_edges_q);
    edge_count_d = done ? '0 : count_inc;
    if (done) begin
      armed_d = 1'b1;
    end
    shift_d = sr;
  end

  ipd_key_match u_key_match (
    .code_i      (shift_d),
    .key_index_o (key_match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b1;
      edge_count_q <= '0;
      shift_q      <= '0;
    end else if (in_accept) begin
      armed_q      <= armed_d;
      edge_count_q <= edge_count_d;
      shift_q      <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      frame_done_q <= done;
      code_q       <= done ? shift_d : '0;
      key_index_q  <= done ? key_match : KeyNone;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_done_o = frame_done_q;
  assign code_o       = code_q;
  assign key_index_o  = key_index_q;

  a_done_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && done |=> armed_q && edge_count_q == '0)
    else $error("frame completion did not rearm");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted word produced no result");

  a_no_frame_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !frame_done_q |-> code_q == '0 && key_index_q == KeyNone)
    else $error("non-frame result carries code");

  a_arm_edge_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && armed_q && !done |=> !armed_q && $stable(shift_q))
    else $error("arming edge changed code bits");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none

module tb;
  import ipd_pkg::*;

  typedef struct packed {
    logic             done;
    logic [CodeW-1:0] code;
    logic [KeyW-1:0]  key;
  } decoded_t;

  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdleLimit  = 5000;
  // an index past the four registers, must be ignored
  localparam logic [CfgIdxW-1:0] CfgNoReg = CfgIdxW'(8'hC5);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [GapW-1:0]     gap_us_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                frame_done_o;
  logic [CodeW-1:0]    code_o;
  logic [KeyW-1:0]     key_index_o;

  ir_pulse_distance_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .gap_us_i     (gap_us_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_done_o (frame_done_o),
    .code_o       (code_o),
    .key_index_o  (key_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder copy: limits and frame state
  logic [GapW-1:0]   one_lim   = OneLimitRst;
  logic [GapW-1:0]   start_lim = StartLimitRst;
  logic [GapW-1:0]   idle_lim  = IdleLimitRst;
  logic [CountW-1:0] frm_edges = FrameEdgesRst;
  logic              armed     = 1'b1;
  logic [CountW-1:0] edge_cnt  = '0;
  logic [CodeW-1:0]  shreg     = '0;

  logic [GapW-1:0] gap_q [$];
  decoded_t        decoded_q [$];
  decoded_t        want_w;

  int unsigned snd_idle_pct = 28;
  int unsigned rcv_stall_pct = 59;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned n_frames = 0;
  int unsigned n_keys = 0;
  int unsigned n_cfg = 0;
  int unsigned n_err = 0;
  int unsigned quiet_cycles = 0;
  logic        in_acc = 1'b0;

  function automatic logic [KeyW-1:0] lookup_key(logic [CodeW-1:0] c);
    logic [KeyW-1:0] k;
    k = KeyNone;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (KeyCodes[i] == c) k = KeyW'(i);
    end
    return k;
  endfunction

  function automatic decoded_t decode_gap(logic [GapW-1:0] g);
    decoded_t r;
    if (armed) begin
      armed = 1'b0;
    end else begin
      if (g >= idle_lim) begin
        edge_cnt = '0;
      end else if (g >= start_lim) begin
        shreg = '0;
        edge_cnt = CountW'(1);
      end
      if (g > one_lim && g < start_lim) shreg = {shreg[CodeW-2:0], 1'b1};
      else if (g < one_lim) shreg = {shreg[CodeW-2:0], 1'b0};
      else if (g > start_lim) shreg = '0;
    end
    edge_cnt = edge_cnt + 1'b1;
    r.done = 1'b0;
    r.code = '0;
    r.key  = KeyNone;
    if (edge_cnt == frm_edges) begin
      edge_cnt = '0;
      armed = 1'b1;
      r.done = 1'b1;
      r.code = shreg;
      r.key  = lookup_key(shreg);
    end
    return r;
  endfunction

  // word accepted at the input: predict its result right away
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      decoded_q.push_back(decode_gap(gap_us_i));
      in_acc <= 1'b1;
    end else begin
      in_acc <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (gap_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid_i <= 1'b1;
        gap_us_i   <= gap_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word: done=%0b code=%h key=%0d", $time,
                 frame_done_o, code_o, key_index_o);
        n_err++;
      end else begin
        want_w = decoded_q.pop_front();
        if (frame_done_o !== want_w.done) begin
          $display("%0t: frame_done expected %0b actual %0b", $time, want_w.done, frame_done_o);
          n_err++;
        end
        if (code_o !== want_w.code) begin
          $display("%0t: code expected %h actual %h", $time, want_w.code, code_o);
          n_err++;
        end
        if (key_index_o !== want_w.key) begin
          $display("%0t: key_index expected %0d actual %0d", $time, want_w.key, key_index_o);
          n_err++;
        end
        n_checked++;
        if (want_w.done) n_frames++;
        if (want_w.key != KeyNone) n_keys++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgOneLimit:   one_lim   = data;
      CfgStartLimit: start_lim = data;
      CfgIdleLimit:  idle_lim  = data;
      CfgFrameEdges: frm_edges = data[CountW-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_gap(logic [GapW-1:0] g);
    gap_q.push_back(g);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (gap_q.size() > 0 || n_checked != n_queued) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // limits ordered with room for zero, one and start gaps
  function automatic bit limits_sane();
    return one_lim >= 1 && int'(start_lim) >= int'(one_lim) + 2 && idle_lim > start_lim;
  endfunction

  function automatic logic [GapW-1:0] noise_gap();
    case ($urandom_range(7))
      0: return one_lim;
      1: return start_lim;
      2: return idle_lim;
      3: return one_lim + 1'b1;
      4: return start_lim - 1'b1;
      5: return $urandom_range(1) ? GapW'(0) : {GapW{1'b1}};
      default: return GapW'($urandom_range(65535));
    endcase
  endfunction

  // idle gap arms or clears the count, so the frame lines up from any state
  task automatic queue_frame(int unsigned nbits);
    logic [CodeW-1:0] word;
    bit               b;
    word = $urandom_range(1) ? KeyCodes[$urandom_range(NumKeys - 1)] : CodeW'($urandom());
    push_gap(GapW'($urandom_range(65535, idle_lim)));
    push_gap(GapW'($urandom_range(idle_lim - 1, start_lim)));
    for (int i = int'(nbits) - 1; i >= 0; i--) begin
      b = (i < CodeW) ? word[i] : 1'($urandom_range(1));
      if (b) push_gap(GapW'($urandom_range(start_lim - 1, one_lim + 1)));
      else push_gap(GapW'($urandom_range(one_lim - 1, 0)));
    end
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned nbits;
    stop_at = n_queued + n;
    nbits = (frm_edges >= 2) ? frm_edges - 2 : 0;
    while (n_queued < stop_at) begin
      pick = $urandom_range(99);
      if (limits_sane() && frm_edges >= 2 && pick < 70) begin
        queue_frame(nbits);
      end else if (limits_sane() && frm_edges >= 2 && pick < 82) begin
        // broken frame: header, then up to a full frame's worth of random bit gaps
        push_gap(GapW'($urandom_range(65535, idle_lim)));
        push_gap(GapW'($urandom_range(idle_lim - 1, start_lim)));
        repeat ($urandom_range(nbits)) push_gap(GapW'($urandom_range(start_lim - 1, 0)));
      end else begin
        repeat ($urandom_range(8, 1)) push_gap(noise_gap());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset limits: boundaries and extremes of the gap
    push_gap(16'hFFFF);
    push_gap(16'd13500);
    push_gap(16'd0);
    push_gap(16'd1299);
    push_gap(16'd1300);
    push_gap(16'd1301);
    push_gap(16'd2499);
    push_gap(16'd2500);
    push_gap(16'd2501);
    push_gap(16'd1);
    push_gap(16'd34999);
    push_gap(16'd35000);
    push_gap(16'h5555);
    push_gap(16'hAAAA);
    push_gap(16'd35001);
    push_gap(16'hFFFE);
    queue_random(380);
    wait_drained();

    cfg_write(CfgOneLimit, 16'd600);
    cfg_write(CfgStartLimit, 16'd1200);
    cfg_write(CfgIdleLimit, 16'd9000);
    cfg_write(CfgFrameEdges, 16'd10);
    queue_random(300);
    wait_drained();

    snd_idle_pct = 59;
    rcv_stall_pct = 28;
    cfg_write(CfgOneLimit, 16'd0);
    cfg_write(CfgStartLimit, 16'hFFFF);
    cfg_write(CfgIdleLimit, 16'hFFFF);
    cfg_write(CfgFrameEdges, 16'd63);
    queue_random(150);
    wait_drained();

    // limits out of order
    cfg_write(CfgOneLimit, 16'hFFFF);
    cfg_write(CfgStartLimit, 16'd0);
    cfg_write(CfgIdleLimit, 16'd0);
    cfg_write(CfgFrameEdges, 16'd2);
    queue_random(100);
    wait_drained();

    // upper data bits dropped: one edge per frame
    cfg_write(CfgOneLimit, OneLimitRst);
    cfg_write(CfgStartLimit, StartLimitRst);
    cfg_write(CfgIdleLimit, IdleLimitRst);
    cfg_write(CfgFrameEdges, 16'hFFC1);
    queue_random(60);
    wait_drained();

    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    // zero frame length: done only on count wrap
    cfg_write(CfgOneLimit, 16'd100);
    cfg_write(CfgStartLimit, 16'd200);
    cfg_write(CfgIdleLimit, 16'hFFFF);
    cfg_write(CfgFrameEdges, 16'd0);
    queue_random(150);
    wait_drained();

    cfg_write(CfgOneLimit, OneLimitRst);
    cfg_write(CfgStartLimit, StartLimitRst);
    cfg_write(CfgIdleLimit, IdleLimitRst);
    cfg_write(CfgFrameEdges, 16'(FrameEdgesRst));
    cfg_write(CfgNoReg, 16'd7);
    queue_random(500);
    hold_req++;
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, decoded_q.size());
      n_err++;
    end
    $display("covered %0d gap words over 7 limit settings, %0d register writes",
             n_checked, n_cfg);
    $display("frames decoded: %0d, of which matched a key: %0d, mismatches: %0d",
             n_frames, n_keys, n_err);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/ipd_pkg.sv
src/ipd_key_match.sv
src/ir_pulse_distance_decoder.sv
tb/sv/tb.sv
